// ===== rtl/core/pet_pkg.sv =====
package pet_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIX_W  = 8;
   localparam int THR_W  = 8;
   localparam int CFG_W  = 11;
   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   // input row runs one past the frame while the last line drains
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
   localparam int ADDR_W = $clog2(MAX_WIDTH);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_THRESHOLD    = 2'd0;
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(1024);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(1024);

   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
   localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

   typedef struct packed {
      logic             action;
      logic [PIX_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_value;
      logic             end_of_row;
      logic             end_of_frame;
   } rsp_type;

   // per-request control handed down the pipeline
   typedef struct packed {
      logic emit;
      logic first_row;
      logic last_row;
      logic first_col;
      logic last_col;
   } step_type;

endpackage

// ===== rtl/core/prewitt_edge_threshold.sv =====
// Prewitt 3x3 edge detector with threshold on a raster stream of 8-bit pixels.
// Request channel (req_*): one pixel per request in raster order, or a flush
// request (action = 1) that pushes a virtual zero pixel. Response channel
// (rsp_*): one edge result (255 or 0) with end_of_row / end_of_frame marks.
// The result for pixel (r,c) comes out with the request that brings pixel
// (r+1,c+1); after a frame's last pixel, frame_width+1 flush requests drain
// the remaining results. Early or idle flush requests are taken and dropped.
// Registers on the csr_* port: threshold (0x0), frame_width (0x4),
// frame_height (0x8). Writing a size restarts the frame.
// Throughput: one request per cycle; each line store reads the column of the
// request being taken while the previous request's column is written back.
// A request is registered in the line stage, then its result in the output register.
// When the receiver stalls the result waits in the output register, one more
// request is held in the line stage, then req_ready drops.
// Reset clears counters, window and handshake state; threshold returns to 0,
// width and height to 1024. Line stores are not cleared.
module prewitt_edge_threshold import pet_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_payload,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   logic [THR_W-1:0]  threshold_ff;
   logic [CFG_W-1:0]  width_ff, height_ff;
   logic              csr_wr, cfg_restart;
   logic [1:0]        reg_idx;
   logic              accept, load, advance, out_free;
   logic [ADDR_W-1:0] addr;
   logic [PIX_W-1:0]  pixel, col_up, col_mid, col_px;
   step_type          step, b_step;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg_restart = csr_wr &&
                        (reg_idx == REG_FRAME_WIDTH || reg_idx == REG_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         width_ff     <= FRAME_WIDTH_RESET;
         height_ff    <= FRAME_HEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_THRESHOLD:    threshold_ff <= csr_pwdata[THR_W-1:0];
            REG_FRAME_WIDTH:  width_ff     <= csr_pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: height_ff    <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_THRESHOLD:    csr_prdata = CSR_DATA_W'(threshold_ff);
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign accept = req_valid && req_ready;

   pet_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_payload),
      .cfg_width   (width_ff),
      .cfg_height  (height_ff),
      .cfg_restart (cfg_restart),
      .load        (load),
      .addr        (addr),
      .pixel       (pixel),
      .step        (step)
   );

   pet_line_buf u_line_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .addr     (addr),
      .pixel    (pixel),
      .step_in  (step),
      .out_free (out_free),
      .ready    (req_ready),
      .advance  (advance),
      .col_up   (col_up),
      .col_mid  (col_mid),
      .col_px   (col_px),
      .b_step   (b_step)
   );

   pet_kernel u_kernel (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .b_step      (b_step),
      .col_up      (col_up),
      .col_mid     (col_mid),
      .col_px      (col_px),
      .threshold   (threshold_ff),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .out_free    (out_free)
   );

endmodule

// ===== rtl/core/pet_ctrl.sv =====
module pet_ctrl import pet_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  req_type             req,
   input  logic [CFG_W-1:0]    cfg_width,
   input  logic [CFG_W-1:0]    cfg_height,
   input  logic                cfg_restart,
   output logic                load,
   output logic [ADDR_W-1:0]   addr,
   output logic [PIX_W-1:0]    pixel,
   output step_type            step
);

   logic [COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [COL_W-1:0] w_eff, ic, oc, ic_inc, oc_inc;
   logic [ROW_W-1:0] h_eff, ir, orow;
   logic             input_done, flush, drop, restart, emit;

   always_comb begin
      if (cfg_width == '0) begin
         w_eff = COL_W'(1);
      end else if (32'(cfg_width) > MAX_WIDTH) begin
         w_eff = COL_W'(MAX_WIDTH);
      end else begin
         w_eff = COL_W'(cfg_width);
      end
      if (cfg_height == '0) begin
         h_eff = ROW_W'(1);
      end else if (32'(cfg_height) > MAX_HEIGHT) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(cfg_height);
      end
   end

   always_comb begin
      input_done = in_row_ff >= h_eff;
      flush      = req.action == ACTION_FLUSH;
      // early or idle flush leaves everything as it is
      drop       = flush && (!input_done || out_row_ff >= h_eff);
      // a pixel after the last one of a frame opens the next frame
      restart    = !flush && input_done;

      ic   = restart ? '0 : in_col_ff;
      ir   = restart ? '0 : in_row_ff;
      oc   = restart ? '0 : out_col_ff;
      orow = restart ? '0 : out_row_ff;

      ic_inc = ic + 1'b1;
      if (ic_inc >= w_eff) begin
         in_col_in = '0;
         in_row_in = ir + 1'b1;
      end else begin
         in_col_in = ic_inc;
         in_row_in = ir;
      end

      emit = (orow < h_eff) &&
             (ir >= ROW_W'(2) || (ir == ROW_W'(1) && ic != '0));

      oc_inc = oc + 1'b1;
      if (!emit) begin
         out_col_in = oc;
         out_row_in = orow;
      end else if (oc_inc >= w_eff) begin
         out_col_in = '0;
         out_row_in = orow + 1'b1;
      end else begin
         out_col_in = oc_inc;
         out_row_in = orow;
      end

      load           = accept && !drop;
      addr           = ic[ADDR_W-1:0];
      pixel          = flush ? '0 : req.pixel;
      step.emit      = emit;
      step.first_row = orow == '0;
      step.last_row  = orow == h_eff - 1'b1;
      step.first_col = oc == '0;
      step.last_col  = oc == w_eff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_restart) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (load) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

`ifndef SYNTHESIS
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      in_col_ff < w_eff) else $error("input column beyond frame width");
   a_out_lags_in: assert property (@(posedge clock) disable iff (reset)
      out_row_ff <= in_row_ff) else $error("output row ahead of input row");
`endif

endmodule

// ===== rtl/core/pet_line_buf.sv =====
module pet_line_buf import pet_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic [ADDR_W-1:0]  addr,
   input  logic [PIX_W-1:0]   pixel,
   input  step_type           step_in,
   input  logic               out_free,
   output logic               ready,
   output logic               advance,
   output logic [PIX_W-1:0]   col_up,
   output logic [PIX_W-1:0]   col_mid,
   output logic [PIX_W-1:0]   col_px,
   output step_type           b_step
);

   logic [PIX_W-1:0]  mem_up  [MAX_WIDTH];
   logic [PIX_W-1:0]  mem_mid [MAX_WIDTH];

   logic              b_valid_ff;
   logic [ADDR_W-1:0] b_addr_ff;
   logic [PIX_W-1:0]  b_px_ff;
   step_type          b_step_ff;
   logic [PIX_W-1:0]  up_rd_ff, mid_rd_ff;
   logic              b_fwd_ff;
   logic [PIX_W-1:0]  fwd_up_ff, fwd_mid_ff;
   logic [PIX_W-1:0]  up_eff, mid_eff;
   logic              hit;

   assign advance = b_valid_ff && out_free;
   assign ready   = !b_valid_ff || advance;
   // same column read while the previous request writes it back (width of one, or a restart)
   assign hit     = load && advance && (addr == b_addr_ff);
   assign up_eff  = b_fwd_ff ? fwd_up_ff : up_rd_ff;
   assign mid_eff = b_fwd_ff ? fwd_mid_ff : mid_rd_ff;

   assign col_up  = up_eff;
   assign col_mid = mid_eff;
   assign col_px  = b_px_ff;
   assign b_step  = b_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (load) begin
         b_valid_ff <= 1'b1;
      end else if (advance) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         b_addr_ff  <= addr;
         b_px_ff    <= pixel;
         b_step_ff  <= step_in;
         b_fwd_ff   <= hit;
         fwd_up_ff  <= mid_eff;
         fwd_mid_ff <= b_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mem_up[b_addr_ff] <= mid_eff;
      end
      if (load) begin
         up_rd_ff <= mem_up[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mem_mid[b_addr_ff] <= b_px_ff;
      end
      if (load) begin
         mid_rd_ff <= mem_mid[addr];
      end
   end

`ifndef SYNTHESIS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load |-> (!b_valid_ff || advance)) else $error("line stage overwritten");
`endif

endmodule

// ===== rtl/core/pet_kernel.sv =====
module pet_kernel import pet_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  step_type           b_step,
   input  logic [PIX_W-1:0]   col_up,
   input  logic [PIX_W-1:0]   col_mid,
   input  logic [PIX_W-1:0]   col_px,
   input  logic [THR_W-1:0]   threshold,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output rsp_type            rsp_payload,
   output logic               out_free
);

   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];
   logic [PIX_W-1:0] mp [9];
   logic [2:0]       row_ok, col_ok;
   logic [PIX_W+1:0] gx_p, gx_n, gy_p, gy_n, ax, ay;
   logic [PIX_W+2:0] mag;
   logic             out_valid_ff;
   rsp_type          out_ff, out_in;

   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = col_up;
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = col_mid;
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = col_px;

      // neighbors outside the frame count as zero
      row_ok = {!b_step.last_row, 1'b1, !b_step.first_row};
      col_ok = {!b_step.last_col, 1'b1, !b_step.first_col};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mp[3*r+c] = (row_ok[r] && col_ok[c]) ? win_in[3*r+c] : '0;
         end
      end

      gx_p = {2'b0, mp[2]} + {2'b0, mp[5]} + {2'b0, mp[8]};
      gx_n = {2'b0, mp[0]} + {2'b0, mp[3]} + {2'b0, mp[6]};
      gy_p = {2'b0, mp[6]} + {2'b0, mp[7]} + {2'b0, mp[8]};
      gy_n = {2'b0, mp[0]} + {2'b0, mp[1]} + {2'b0, mp[2]};
      ax   = (gx_p >= gx_n) ? gx_p - gx_n : gx_n - gx_p;
      ay   = (gy_p >= gy_n) ? gy_p - gy_n : gy_n - gy_p;
      mag  = {1'b0, ax} + {1'b0, ay};

      out_in.edge_value   = (mag > {3'b0, threshold}) ? EDGE_ON : EDGE_OFF;
      out_in.end_of_row   = b_step.last_col;
      out_in.end_of_frame = b_step.last_col && b_step.last_row;
   end

   assign out_free    = !out_valid_ff || rsp_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (advance) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && b_step.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && b_step.emit) begin
         out_ff <= out_in;
      end
   end

`ifndef SYNTHESIS
   a_eof_is_eor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.end_of_frame) |-> rsp_payload.end_of_row)
      else $error("end of frame without end of row");
`endif

endmodule

// ===== dv/tb_prewitt_edge_threshold.sv =====
`timescale 1ns / 1ps

module tb_prewitt_edge_threshold;
   import pet_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   rsp_type               rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   prewitt_edge_threshold dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always #2 clock = ~clock;

   req_type stream_q[$];
   rsp_type edge_q[$];
   int      queued_items = 0;
   int      mismatches = 0;
   int      quiet_cycles = 0;
   logic    req_taken = 1'b0;

   // shadow of the block: configuration, line stores, window, raster counters
   logic [THR_W-1:0] cfg_threshold;
   logic [CFG_W-1:0] cfg_width;
   logic [CFG_W-1:0] cfg_height;
   logic [PIX_W-1:0] line_top [0:MAX_WIDTH-1];
   logic [PIX_W-1:0] line_mid [0:MAX_WIDTH-1];
   logic [PIX_W-1:0] win_px [0:8];
   int               in_col, in_row, out_col, out_row;

   function automatic int eff_size(input int v, input int cap);
      if (v < 1) return 1;
      if (v > cap) return cap;
      return v;
   endfunction

   function automatic void rewind_frame();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function automatic void reset_model();
      cfg_threshold = '0;
      cfg_width = FRAME_WIDTH_RESET;
      cfg_height = FRAME_HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_top[i] = '0;
         line_mid[i] = '0;
      end
      for (int i = 0; i < 9; i++) win_px[i] = '0;
      rewind_frame();
   endfunction

   // advance the shadow by one request; returns 1 when a result is due
   function automatic bit next_edge(input req_type item, output rsp_type res);
      int               w, h, ic, ir, gx, gy, rr, cc, k, dr, dc;
      logic [PIX_W-1:0] px, up, mid;
      bit               frame_in;
      w = eff_size(int'(cfg_width), MAX_WIDTH);
      h = eff_size(int'(cfg_height), MAX_HEIGHT);
      px = item.pixel;
      frame_in = (in_row >= h);
      res = '0;
      if (item.action == ACTION_FLUSH) begin
         if (!frame_in || out_row >= h) return 0;
         px = '0;
      end else if (frame_in) begin
         // new frame starts, anything still draining is dropped
         rewind_frame();
      end
      ic = in_col;
      ir = in_row;
      up = line_top[ic];
      mid = line_mid[ic];
      for (k = 0; k < 3; k++) begin
         win_px[3*k] = win_px[3*k+1];
         win_px[3*k+1] = win_px[3*k+2];
      end
      win_px[2] = up;
      win_px[5] = mid;
      win_px[8] = px;
      line_top[ic] = mid;
      line_mid[ic] = px;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (out_row >= h) return 0;
      if (!(ir >= 2 || (ir == 1 && ic >= 1))) return 0;
      gx = 0;
      gy = 0;
      for (dr = -1; dr <= 1; dr++) begin
         for (dc = -1; dc <= 1; dc++) begin
            rr = out_row + dr;
            cc = out_col + dc;
            k = (dr + 1) * 3 + dc + 1;
            if (rr >= 0 && cc >= 0 && rr < h && cc < w) begin
               gx += dc * int'(win_px[k]);
               gy += dr * int'(win_px[k]);
            end
         end
      end
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      res.edge_value = (gx + gy > int'(cfg_threshold)) ? EDGE_ON : EDGE_OFF;
      res.end_of_row = (out_col == w - 1);
      res.end_of_frame = (out_col == w - 1) && (out_row == h - 1);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      return 1;
   endfunction

   task automatic check_value(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // sender: bursts of requests with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin : sender
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (stream_q.size() != 0) begin
            req_valid <= 1'b1;
            req_payload <= stream_q.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: ready patterns from a 16-bit mask, from always-ready to stall-heavy
   logic [15:0] stall_mask = '1;
   logic [3:0]  stall_pos = '0;
   always @(negedge clock) begin : receiver
      if (stall_pos == 0) begin
         case ($urandom_range(0, 3))
            0: stall_mask = '1;
            1: stall_mask = 16'($urandom) | 16'($urandom);
            2: stall_mask = 16'($urandom) & 16'($urandom);
            default: stall_mask = 16'($urandom);
         endcase
      end
      rsp_ready <= stall_mask[stall_pos];
      stall_pos = stall_pos + 1'b1;
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (reset) begin
         reset_model();
         edge_q.delete();
      end else begin
         // a request's response never comes in the same cycle: check, then predict
         if (rsp_valid && rsp_ready) begin
            if (edge_q.size() == 0) begin
               $error("unexpected response: edge_value %0d", rsp_payload.edge_value);
               mismatches++;
            end else begin
               want = edge_q.pop_front();
               check_value("edge_value", want.edge_value, rsp_payload.edge_value);
               check_value("end_of_row", want.end_of_row, rsp_payload.end_of_row);
               check_value("end_of_frame", want.end_of_frame, rsp_payload.end_of_frame);
            end
         end
         if (req_valid && req_ready) begin
            if (next_edge(req_payload, want)) edge_q.push_back(want);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("** prewitt_edge_threshold: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_THRESHOLD: cfg_threshold = data[THR_W-1:0];
         REG_FRAME_WIDTH: begin
            cfg_width = data[CFG_W-1:0];
            rewind_frame();
         end
         REG_FRAME_HEIGHT: begin
            cfg_height = data[CFG_W-1:0];
            rewind_frame();
         end
         default: ;
      endcase
   endtask

   task automatic csr_check(input logic [1:0] idx, input string name,
                            input logic [31:0] want);
      logic [31:0] got;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      check_value(name, want, got);
   endtask

   task automatic drain();
      while (stream_q.size() != 0 || req_valid || edge_q.size() != 0) @(posedge clock);
      // flush requests that yield nothing may still be in the pipeline
      repeat (8) @(posedge clock);
   endtask

   // upper pwdata bits carry junk to exercise register masking
   task automatic set_config(input int thr, input int w_raw, input int h_raw);
      drain();
      csr_write(REG_THRESHOLD, ($urandom << THR_W) | thr);
      csr_write(REG_FRAME_WIDTH, ($urandom << CFG_W) | w_raw);
      csr_write(REG_FRAME_HEIGHT, ($urandom << CFG_W) | h_raw);
      csr_check(REG_THRESHOLD, "threshold", cfg_threshold);
      csr_check(REG_FRAME_WIDTH, "frame_width", cfg_width);
      csr_check(REG_FRAME_HEIGHT, "frame_height", cfg_height);
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] v);
      req_type item;
      item.action = ACTION_PIXEL;
      item.pixel = v;
      stream_q.push_back(item);
      queued_items++;
   endtask

   task automatic push_flush();
      req_type item;
      item.action = ACTION_FLUSH;
      item.pixel = PIX_W'($urandom);
      stream_q.push_back(item);
      queued_items++;
   endtask

   function automatic logic [PIX_W-1:0] gen_pixel(input int mode, input int base);
      int v;
      case (mode)
         0: v = $urandom_range(0, 255);
         1: v = $urandom_range(0, 1) ? 255 : 0;
         default: begin
            // low-contrast texture, gradient sums near small thresholds
            v = base + int'($urandom_range(0, 6)) - 3;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
      endcase
      return PIX_W'(v);
   endfunction

   task automatic queue_frame(input int w, input int h, input int flushes);
      int mode, base, i;
      mode = $urandom_range(0, 2);
      base = $urandom_range(0, 255);
      for (i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 24) == 0) push_flush();   // flush, dropped if mid-frame
         push_pixel(gen_pixel(mode, base));
      end
      repeat (flushes) push_flush();
   endtask

   task automatic random_phase(input int thr, input int w_raw, input int h_raw,
                               input int budget);
      int w, h, start, n;
      set_config(thr, w_raw, h_raw);
      w = eff_size(w_raw, MAX_WIDTH);
      h = eff_size(h_raw, MAX_HEIGHT);
      start = queued_items;
      while (queued_items - start < budget) begin
         case ($urandom_range(0, 9))
            7: queue_frame(w, h, $urandom_range(0, w));   // drain cut short
            8: repeat ($urandom_range(1, 3)) push_flush();
            9: begin
               // partial frame, shifts the raster alignment of what follows
               n = $urandom_range(1, w * h);
               repeat (n) push_pixel(PIX_W'($urandom));
            end
            default: queue_frame(w, h, w + 1);
         endcase
      end
   endtask

   initial begin : stimulus
      int w_raw, h_raw, thr;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_check(REG_THRESHOLD, "threshold", cfg_threshold);
      csr_check(REG_FRAME_WIDTH, "frame_width", cfg_width);
      csr_check(REG_FRAME_HEIGHT, "frame_height", cfg_height);

      // 3x3 frame with extremes, an idle flush, an early flush, and a flush past the drain
      set_config(0, 3, 3);
      push_flush();
      push_pixel(8'd0);
      push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd255);
      push_flush();
      push_pixel(8'd255);
      push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd0);
      push_pixel(8'd255);
      repeat (4) push_flush();
      push_flush();

      // single-row frame
      set_config(254, 4, 1);
      push_pixel(8'd0);
      push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd255);
      repeat (5) push_flush();

      repeat (7) begin
         case ($urandom_range(0, 5))
            0: w_raw = 0;
            1: w_raw = 1;
            2: w_raw = 2;
            default: w_raw = $urandom_range(3, 12);
         endcase
         case ($urandom_range(0, 5))
            0: h_raw = 0;
            1: h_raw = 1;
            2: h_raw = 2;
            default: h_raw = $urandom_range(3, 8);
         endcase
         case ($urandom_range(0, 3))
            0: thr = 0;
            1: thr = 255;
            default: thr = $urandom_range(0, 255);
         endcase
         random_phase(thr, w_raw, h_raw, 95);
      end
      random_phase($urandom_range(0, 255), 0, 0, 30);

      // oversized sizes read back as written; a short partial row yields nothing
      set_config(255, 2047, 2047);
      repeat (24) push_pixel(PIX_W'($urandom));

      drain();
      if (mismatches == 0) begin
         $display("** prewitt_edge_threshold: PASSED **");
      end else begin
         $display("** prewitt_edge_threshold: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/pet_pkg.sv
rtl/core/pet_ctrl.sv
rtl/core/pet_line_buf.sv
rtl/core/pet_kernel.sv
rtl/core/prewitt_edge_threshold.sv
dv/tb_prewitt_edge_threshold.sv
